[design/sbda_pkg.sv]
// Shared constants and types for the signed binary to decimal ASCII converter.
package sbda_pkg;

	localparam int VALUE_BITS = 64;
	localparam int VALUE_WIDTH_DEF = 64;
	localparam int CHAR_BITS = 8;

	localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 8'd48;
	localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 8'd45;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic negative;
	} emit_cmd_t;

endpackage

[design/signed_binary_to_decimal_ascii.sv]
// Top level of the signed binary to decimal ASCII converter: sequencer and datapath wiring.
//
//  channel   signals                      handshake
//  --------  ---------------------------  ----------------------------------------
//  input     value[63:0]                  taken when start is high and busy is low
//  result    character[7:0], last         one cycle each, marked by strobe
//
// An accepted value is shifted through the bit-serial double dabble unit one magnitude
// bit per cycle and then handed over to the emitter, which gives the minus sign first
// if negative and then walks the BCD digit slots (19 at 64 bits) one at a time, with
// leading zero slots giving no character.
// Reset clears all control state; busy stays high until the last character is out.
// Results cannot be held off by the receiver.
module signed_binary_to_decimal_ascii #(
	parameter int VALUE_WIDTH = sbda_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [sbda_pkg::VALUE_BITS-1:0]      value,
	output logic [sbda_pkg::CHAR_BITS-1:0]       character,
	output logic                                 last,
	output logic                                 strobe
);

	// decimal digits of 2^(VALUE_WIDTH-1)
	localparam int DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;

	sbda_pkg::state_t     state_q;
	sbda_pkg::state_t     state_next;
	sbda_pkg::emit_cmd_t  emit_cmd;
	logic                 neg_q;
	logic                 accept;
	logic                 dabble_idle;
	logic                 emit_idle;
	logic [VALUE_WIDTH-1:0] raw;
	logic [VALUE_WIDTH-1:0] magnitude;
	logic [DIGITS*4-1:0]  bcd;

	assign accept = start && !busy;
	assign raw = value[VALUE_WIDTH-1:0];
	// unsigned negation covers the most negative value too
	assign magnitude = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sbda_pkg::ST_IDLE;
			neg_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (accept) begin
				neg_q <= raw[VALUE_WIDTH-1];
			end
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			sbda_pkg::ST_IDLE: begin
				if (start) begin
					state_next = sbda_pkg::ST_CONVERT;
				end
			end
			sbda_pkg::ST_CONVERT: begin
				if (dabble_idle) begin
					state_next = sbda_pkg::ST_EMIT;
				end
			end
			sbda_pkg::ST_EMIT: begin
				if (emit_idle) begin
					state_next = sbda_pkg::ST_IDLE;
				end
			end
			default: state_next = sbda_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		busy = 1'b1;
		emit_cmd.load = 1'b0;
		emit_cmd.negative = neg_q;
		case (state_q)
			sbda_pkg::ST_IDLE: busy = 1'b0;
			sbda_pkg::ST_CONVERT: emit_cmd.load = dabble_idle;
			sbda_pkg::ST_EMIT: busy = 1'b1;
			default: busy = 1'b1;
		endcase
	end

	sbda_dabble #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.DIGITS(DIGITS)
	) u_dabble (
		.clk(clk),
		.arst_n(arst_n),
		.load(accept),
		.magnitude(magnitude),
		.bcd(bcd),
		.idle(dabble_idle)
	);

	sbda_emit #(
		.DIGITS(DIGITS)
	) u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(emit_cmd),
		.bcd(bcd),
		.character(character),
		.last(last),
		.strobe(strobe),
		.idle(emit_idle)
	);

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> busy) else $error("character strobed while idle");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (character == sbda_pkg::ASCII_MINUS) |-> !last)
		else $error("minus sign flagged as last character");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe) else $error("character after last of run");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy) else $error("busy not raised after accepted transaction");

	a_emit_after_convert: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> dabble_idle) else $error("character emitted during conversion");

endmodule

[design/sbda_dabble.sv]
// Bit-serial double dabble: shifts the magnitude in MSB first, one bit per cycle, into BCD.
module sbda_dabble #(
	parameter int VALUE_WIDTH = sbda_pkg::VALUE_WIDTH_DEF,
	parameter int DIGITS = 19
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  logic [VALUE_WIDTH-1:0]  magnitude,
	output logic [DIGITS*4-1:0]     bcd,
	output logic                    idle
);

	localparam int CW = $clog2(VALUE_WIDTH + 1);

	logic [VALUE_WIDTH-1:0] mag_q;
	logic [DIGITS*4-1:0]    bcd_q;
	logic [DIGITS*4-1:0]    adj;
	logic [CW-1:0]          cnt_q;

	// add 3 to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= CW'(VALUE_WIDTH);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mag_q <= magnitude;
			bcd_q <= '0;
		end else if (cnt_q != '0) begin
			bcd_q <= {adj[DIGITS*4-2:0], mag_q[VALUE_WIDTH-1]};
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
		end
	end

	assign bcd = bcd_q;
	assign idle = (cnt_q == '0);

endmodule

[design/sbda_emit.sv]
// Digit shifter: walks the BCD digits from the top, drops leading zeros, drives ASCII out.
module sbda_emit #(
	parameter int DIGITS = 19
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  sbda_pkg::emit_cmd_t                   cmd,
	input  logic [DIGITS*4-1:0]                   bcd,
	output logic [sbda_pkg::CHAR_BITS-1:0]        character,
	output logic                                  last,
	output logic                                  strobe,
	output logic                                  idle
);

	localparam int IW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	logic [DIGITS*4-1:0]               digits_q;
	logic [IW-1:0]                     idx_q;
	logic                              active_q;
	logic                              neg_q;
	logic                              started_q;
	logic [3:0]                        top_digit;
	logic                              final_digit;
	logic                              show_digit;
	logic                              strobe_q;
	logic                              last_q;
	logic [sbda_pkg::CHAR_BITS-1:0]    character_q;

	assign top_digit = digits_q[DIGITS*4-1 -: 4];
	assign final_digit = (idx_q == IW'(DIGITS - 1));
	assign show_digit = started_q || (top_digit != 4'd0) || final_digit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			neg_q <= 1'b0;
			started_q <= 1'b0;
			idx_q <= '0;
			strobe_q <= 1'b0;
		end else if (cmd.load) begin
			active_q <= 1'b1;
			neg_q <= cmd.negative;
			started_q <= 1'b0;
			idx_q <= '0;
			strobe_q <= 1'b0;
		end else if (active_q) begin
			if (neg_q) begin
				neg_q <= 1'b0;
				strobe_q <= 1'b1;
			end else begin
				strobe_q <= show_digit;
				started_q <= show_digit;
				idx_q <= idx_q + 1'b1;
				if (final_digit) begin
					active_q <= 1'b0;
				end
			end
		end else begin
			strobe_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			digits_q <= bcd;
		end else if (active_q) begin
			if (neg_q) begin
				character_q <= sbda_pkg::ASCII_MINUS;
				last_q <= 1'b0;
			end else begin
				character_q <= sbda_pkg::ASCII_ZERO + {4'd0, top_digit};
				last_q <= final_digit;
				digits_q <= {digits_q[DIGITS*4-5:0], 4'd0};
			end
		end
	end

	assign character = character_q;
	assign last = last_q;
	assign strobe = strobe_q;
	assign idle = !active_q;

endmodule

[tb/signed_binary_to_decimal_ascii_tb.sv]
// Self-checking testbench for the signed binary to decimal ASCII converter.
module signed_binary_to_decimal_ascii_tb;

	localparam int VALUE_BITS = sbda_pkg::VALUE_BITS;
	localparam int CHAR_BITS = sbda_pkg::CHAR_BITS;
	localparam int DIGIT_SLOTS = 19;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 100;

	typedef struct {
		logic [CHAR_BITS-1:0] code;
		logic                 final_char;
	} text_char_t;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [VALUE_BITS-1:0] value;
	logic [CHAR_BITS-1:0]  character;
	logic                  last;
	logic                  strobe;

	text_char_t pending_text[$];
	int         mismatch_count;
	int         values_sent;
	int         negatives_sent;
	int         chars_checked;
	int         stall_cycles;
	bit         gaps_on;

	signed_binary_to_decimal_ascii i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.character (character),
		.last      (last),
		.strobe    (strobe)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $time, what);
		mismatch_count++;
	endtask

	// Push the decimal text of one value, most significant character first.
	function automatic void predict_text(input logic [VALUE_BITS-1:0] v);
		logic                  negative;
		logic [VALUE_BITS-1:0] magnitude;
		logic [3:0]            digits[DIGIT_SLOTS];
		int                    n;
		text_char_t            c;
		negative = v[VALUE_BITS-1];
		magnitude = negative ? (~v + 1'b1) : v;
		n = 0;
		do begin
			digits[n] = 4'(magnitude % 10);
			n++;
			magnitude = magnitude / 10;
		end while (magnitude != 0 && n < DIGIT_SLOTS);
		if (negative) begin
			c.code = sbda_pkg::ASCII_MINUS;
			c.final_char = 1'b0;
			pending_text.push_back(c);
		end
		for (int i = n - 1; i >= 0; i--) begin
			c.code = sbda_pkg::ASCII_ZERO + CHAR_BITS'(digits[i]);
			c.final_char = (i == 0);
			pending_text.push_back(c);
		end
	endfunction

	// Hold start low while the value bus carries junk.
	task automatic idle_burst(input int n);
		start <= 1'b0;
		repeat (n) begin
			value <= {$urandom, $urandom};
			@(negedge clk);
		end
	endtask

	// Called at a falling edge; returns at the falling edge after the transaction.
	task automatic send_value(input logic [VALUE_BITS-1:0] v);
		if (gaps_on && $urandom_range(0, 2) == 0)
			idle_burst($urandom_range(1, 14));
		start <= 1'b1;
		value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predict_text(v);
		values_sent++;
		if (v[VALUE_BITS-1])
			negatives_sent++;
		@(negedge clk);
	endtask

	function automatic logic [VALUE_BITS-1:0] power_of_ten(input int k);
		logic [VALUE_BITS-1:0] p;
		p = 1;
		repeat (k)
			p = p * 10;
		return p;
	endfunction

	task automatic test_directed_text();
		logic [VALUE_BITS-1:0] picks[$];
		picks = '{
			64'd0, 64'd1, '1, 64'd9, 64'd10, -64'd9, -64'd10, 64'd99, -64'd100,
			64'd4294967296, 64'd999999999999999999, 64'd1000000000000000000,
			-64'd999999999999999999, -64'd1000000000000000000,
			64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
			64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'd1234567890, -64'd7
		};
		foreach (picks[i])
			send_value(picks[i]);
	endtask

	task automatic test_random_values(input int count);
		logic [VALUE_BITS-1:0] v;
		repeat (count) begin
			// Toggle gap mode now and then to get stretches without idling.
			if ($urandom_range(0, 9) == 0)
				gaps_on = !gaps_on;
			case ($urandom_range(0, 4))
				0: v = {$urandom, $urandom};
				1: v = {$urandom, $urandom} >> $urandom_range(0, 63);
				2: v = VALUE_BITS'($urandom_range(0, 1000));
				3: v = power_of_ten($urandom_range(0, 18)) + $urandom_range(0, 2) - 1;
				default: v = 64'h7FFF_FFFF_FFFF_FFFF - $urandom_range(0, 3);
			endcase
			if ($urandom_range(0, 1) == 1)
				v = ~v + 1'b1;
			send_value(v);
		end
	endtask

	task automatic test_back_to_back(input int count);
		gaps_on = 1'b0;
		repeat (count)
			send_value({$urandom, $urandom} >> $urandom_range(0, 63));
		start <= 1'b0;
	endtask

	// Compare each character against the oldest expectation.
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && strobe) begin
			if (pending_text.size() == 0) begin
				report_mismatch($sformatf("character 0x%02h with nothing expected", character));
			end else begin
				want = pending_text.pop_front();
				chars_checked++;
				if (character !== want.code)
					report_mismatch($sformatf("character 0x%02h, want 0x%02h",
						character, want.code));
				if (last !== want.final_char)
					report_mismatch($sformatf("last %b, want %b on character 0x%02h",
						last, want.final_char, want.code));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		values_sent = 0;
		negatives_sent = 0;
		gaps_on = 1'b1;
		start = 1'b0;
		value = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_text();
		test_random_values(60);
		test_back_to_back(20);

		while (pending_text.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("converted %0d values (%0d negative), checked %0d characters",
			values_sent, negatives_sent, chars_checked);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
